>>> design/sme_pkg.sv
// sme_pkg: shared types and constants of the stack machine executor
// opcodes, fault codes, default sizes and the execute result record
// no dependencies
`default_nettype none

package sme_pkg;

  // fixed field widths
  localparam int unsigned KIND_W  = 4;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned DEPTH_W = 7;
  localparam int unsigned FAULT_W = 2;

  // default sizes of the stores
  localparam int unsigned DEF_STACK_DEPTH = 64;
  localparam int unsigned DEF_MEM_WORDS   = 16;

  // instruction opcodes; codes above noop behave as noop
  typedef enum logic [KIND_W-1:0] {
    KIND_ADD   = 4'd0,
    KIND_NOR   = 4'd1,
    KIND_IFZ   = 4'd2,
    KIND_HALT  = 4'd3,
    KIND_LOAD  = 4'd4,
    KIND_STORE = 4'd5,
    KIND_POP   = 4'd6,
    KIND_PUSHI = 4'd7,
    KIND_NOOP  = 4'd8
  } kind_e;

  // fault codes reported per item
  typedef enum logic [FAULT_W-1:0] {
    FLT_OK    = 2'd0,
    FLT_UNDER = 2'd1,
    FLT_OVER  = 2'd2,
    FLT_ADDR  = 2'd3
  } fault_e;

  // next-state record produced by the execute unit
  typedef struct packed {
    logic              executed;
    fault_e            fault;
    logic              halt;
    logic [WORD_W-1:0] skip;
    logic [WORD_W-1:0] top;
  } exec_res_t;

endpackage

`default_nettype wire

>>> design/sme_if.sv
// sme_if: valid/ready channels of the stack machine executor
// instruction channel and result channel; depends on sme_pkg
`default_nettype none

interface sme_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [sme_pkg::KIND_W-1:0]           kind;
  logic signed [sme_pkg::WORD_W-1:0]    operand;

  modport source (output valid, kind, operand, input ready);
  modport sink   (input valid, kind, operand, output ready);
endinterface

interface sme_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 executed;
  logic signed [sme_pkg::WORD_W-1:0]    top_value;
  logic [sme_pkg::DEPTH_W-1:0]          stack_depth;
  logic                                 halted;
  logic [sme_pkg::FAULT_W-1:0]          fault;

  modport source (output valid, executed, top_value, stack_depth, halted, fault,
                  input ready);
  modport sink   (input valid, executed, top_value, stack_depth, halted, fault,
                  output ready);
endinterface

`default_nettype wire

>>> design/sme_ram.sv
// sme_ram: generic synchronous ram, one write port, two registered read ports
// no dependencies
`default_nettype none

module sme_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered reads
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

>>> design/sme_exec.sv
// sme_exec: execute unit, computes the next machine state for one instruction
// from the cached top, the two stack entries below it and the memory word
// depends on sme_pkg
`default_nettype none

module sme_exec #(
  parameter int unsigned STACK_DEPTH = sme_pkg::DEF_STACK_DEPTH,
  parameter int unsigned MEM_WORDS   = sme_pkg::DEF_MEM_WORDS,
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1)
) (
  input  wire logic [sme_pkg::KIND_W-1:0] kind_i,
  input  wire logic [sme_pkg::WORD_W-1:0] operand_i,
  input  wire logic [SPW-1:0]             sp_i,
  input  wire logic [sme_pkg::WORD_W-1:0] top_i,
  input  wire logic [sme_pkg::WORD_W-1:0] second_i,
  input  wire logic [sme_pkg::WORD_W-1:0] third_i,
  input  wire logic [sme_pkg::WORD_W-1:0] mdata_i,
  input  wire logic                       halt_i,
  input  wire logic [sme_pkg::WORD_W-1:0] skip_i,
  output sme_pkg::exec_res_t              res_o,
  output logic      [SPW-1:0]             sp_o,
  output logic                            push_we_o,
  output logic                            store_we_o
);

  logic sp_lt1;
  logic sp_lt2;
  logic sp_full;
  logic bad_addr;

  assign sp_lt1   = (sp_i < SPW'(1));
  assign sp_lt2   = (sp_i < SPW'(2));
  assign sp_full  = (sp_i >= SPW'(STACK_DEPTH));
  assign bad_addr = (top_i >= sme_pkg::WORD_W'(MEM_WORDS));

  // opcode decode and next state
  always_comb begin
    res_o.executed = 1'b1;
    res_o.fault    = sme_pkg::FLT_OK;
    res_o.halt     = halt_i;
    res_o.skip     = skip_i;
    res_o.top      = top_i;
    sp_o           = sp_i;
    push_we_o      = 1'b0;
    store_we_o     = 1'b0;
    if (halt_i) begin
      res_o.executed = 1'b0;
    end else if (skip_i != '0) begin
      res_o.executed = 1'b0;
      res_o.skip     = skip_i - sme_pkg::WORD_W'(1);
    end else begin
      unique case (sme_pkg::kind_e'(kind_i))
        sme_pkg::KIND_ADD, sme_pkg::KIND_NOR: begin
          if (sp_lt2) begin
            res_o.fault = sme_pkg::FLT_UNDER;
          end else begin
            res_o.top = (kind_i == sme_pkg::KIND_ADD) ? (top_i + second_i)
                                                      : ~(top_i | second_i);
            sp_o      = sp_i - SPW'(1);
          end
        end
        sme_pkg::KIND_IFZ: begin
          if (sp_lt1) begin
            res_o.fault = sme_pkg::FLT_UNDER;
          end else begin
            res_o.top = second_i;
            sp_o      = sp_i - SPW'(1);
            if (top_i == '0 && !operand_i[sme_pkg::WORD_W-1]) begin
              res_o.skip = operand_i;
            end
          end
        end
        sme_pkg::KIND_HALT: begin
          res_o.halt = 1'b1;
        end
        sme_pkg::KIND_LOAD: begin
          if (sp_lt1) begin
            res_o.fault = sme_pkg::FLT_UNDER;
          end else if (bad_addr) begin
            res_o.fault = sme_pkg::FLT_ADDR;
          end else begin
            res_o.top = mdata_i;
          end
        end
        sme_pkg::KIND_STORE: begin
          if (sp_lt2) begin
            res_o.fault = sme_pkg::FLT_UNDER;
          end else if (bad_addr) begin
            res_o.fault = sme_pkg::FLT_ADDR;
          end else begin
            store_we_o = 1'b1;
            res_o.top  = third_i;
            sp_o       = sp_i - SPW'(2);
          end
        end
        sme_pkg::KIND_POP: begin
          if (sp_lt1) begin
            res_o.fault = sme_pkg::FLT_UNDER;
          end else begin
            res_o.top = second_i;
            sp_o      = sp_i - SPW'(1);
          end
        end
        sme_pkg::KIND_PUSHI: begin
          if (sp_full) begin
            res_o.fault = sme_pkg::FLT_OVER;
          end else begin
            // spill the old top below the new one
            push_we_o = !sp_lt1;
            res_o.top = operand_i;
            sp_o      = sp_i + SPW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/stack_machine_executor_top.sv
// stack_machine_executor_top: stack machine with a cached top of stack,
// an operand stack ram and a data memory ram
// depends on sme_pkg, sme_if, sme_ram, sme_exec
//
//   channel    dir  handshake          payload
//   item_i     in   valid / ready      kind, operand
//   result_o   out  valid / ready      executed, top_value, stack_depth, halted, fault
//
// each item is accepted, then executed: the accept edge launches the stack and
// memory reads addressed by the stack pointer and the cached top, and the
// execute edge executes, writes back and loads the result register.
// after reset the data memory is cleared one word a cycle, with item_i.ready low.
// a waiting result does not block the next accept; execution waits only
// while the result register is full and not being taken.
`default_nettype none

module stack_machine_executor_top #(
  parameter int unsigned STACK_DEPTH = sme_pkg::DEF_STACK_DEPTH,
  parameter int unsigned MEM_WORDS   = sme_pkg::DEF_MEM_WORDS
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sme_in_if.sink     item_i,
  sme_out_if.source  result_o
);

  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned MAW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int unsigned WW  = sme_pkg::WORD_W;

  // control and machine state
  logic                        busy_q, busy_d;
  logic                        clr_q, clr_d;
  logic [MAW-1:0]              clr_cnt_q, clr_cnt_d;
  logic [sme_pkg::KIND_W-1:0]  kind_q;
  logic [WW-1:0]               operand_q;
  logic [SPW-1:0]              sp_q, sp_d;
  logic [WW-1:0]               top_q;
  logic                        halt_q;
  logic [WW-1:0]               skip_q;

  // result register
  logic                        ovalid_q, ovalid_d;
  logic                        oexec_q;
  logic [WW-1:0]               otop_q;
  logic [sme_pkg::DEPTH_W-1:0] odepth_q;
  logic                        ohalt_q;
  logic [sme_pkg::FAULT_W-1:0] ofault_q;

  logic                        accept;
  logic                        exe;
  logic [WW-1:0]               second;
  logic [WW-1:0]               third;
  logic [WW-1:0]               mdata;
  logic [SPW-1:0]              sp_m1, sp_m2, sp_m3;
  sme_pkg::exec_res_t          res;
  logic                        push_we;
  logic                        store_we;
  logic                        dm_we;
  logic [MAW-1:0]              dm_waddr;
  logic [WW-1:0]               dm_wdata;
  logic [SPW+sme_pkg::DEPTH_W-1:0] sp_ext;

  // handshake
  assign item_i.ready = !busy_q && !clr_q;
  assign accept       = item_i.valid && item_i.ready;
  assign exe          = busy_q && (!ovalid_q || result_o.ready);

  assign sp_m1 = sp_q - SPW'(1);
  assign sp_m2 = sp_q - SPW'(2);
  assign sp_m3 = sp_q - SPW'(3);

  // operand stack below the cached top
  sme_ram #(
    .WIDTH (WW),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i     (clk_i),
    .we_i      (exe && push_we),
    .waddr_i   (sp_m1[SAW-1:0]),
    .wdata_i   (top_q),
    .raddr_a_i (sp_m2[SAW-1:0]),
    .raddr_b_i (sp_m3[SAW-1:0]),
    .rdata_a_o (second),
    .rdata_b_o (third)
  );

  // data memory, cleared by a sweep after reset
  assign dm_we    = clr_q || (exe && store_we);
  assign dm_waddr = clr_q ? clr_cnt_q : top_q[MAW-1:0];
  assign dm_wdata = clr_q ? '0 : second;

  sme_ram #(
    .WIDTH (WW),
    .DEPTH (MEM_WORDS)
  ) u_data_ram (
    .clk_i     (clk_i),
    .we_i      (dm_we),
    .waddr_i   (dm_waddr),
    .wdata_i   (dm_wdata),
    .raddr_a_i (top_q[MAW-1:0]),
    .raddr_b_i (top_q[MAW-1:0]),
    .rdata_a_o (mdata),
    .rdata_b_o ()
  );

  // execute unit
  sme_exec #(
    .STACK_DEPTH (STACK_DEPTH),
    .MEM_WORDS   (MEM_WORDS)
  ) u_exec (
    .kind_i     (kind_q),
    .operand_i  (operand_q),
    .sp_i       (sp_q),
    .top_i      (top_q),
    .second_i   (second),
    .third_i    (third),
    .mdata_i    (mdata),
    .halt_i     (halt_q),
    .skip_i     (skip_q),
    .res_o      (res),
    .sp_o       (sp_d),
    .push_we_o  (push_we),
    .store_we_o (store_we)
  );

  // control next state
  always_comb begin
    busy_d    = busy_q;
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    ovalid_d  = ovalid_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (exe) begin
      busy_d = 1'b0;
    end
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + MAW'(1);
      if (clr_cnt_q == MAW'(MEM_WORDS - 1)) begin
        clr_d = 1'b0;
      end
    end
    if (exe) begin
      ovalid_d = 1'b1;
    end else if (result_o.ready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      ovalid_q  <= 1'b0;
      sp_q      <= '0;
      halt_q    <= 1'b0;
      skip_q    <= '0;
    end else begin
      busy_q    <= busy_d;
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
      ovalid_q  <= ovalid_d;
      if (exe) begin
        sp_q   <= sp_d;
        halt_q <= res.halt;
        skip_q <= res.skip;
      end
    end
  end

  // instruction register and cached top
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q    <= item_i.kind;
      operand_q <= item_i.operand;
    end
    if (exe) begin
      top_q <= res.top;
    end
  end

  // result register
  assign sp_ext = (SPW + sme_pkg::DEPTH_W)'(sp_d);

  always_ff @(posedge clk_i) begin
    if (exe) begin
      oexec_q  <= res.executed;
      otop_q   <= (sp_d == '0) ? '0 : res.top;
      odepth_q <= sp_ext[sme_pkg::DEPTH_W-1:0];
      ohalt_q  <= res.halt;
      ofault_q <= res.fault;
    end
  end

  assign result_o.valid       = ovalid_q;
  assign result_o.executed    = oexec_q;
  assign result_o.top_value   = otop_q;
  assign result_o.stack_depth = odepth_q;
  assign result_o.halted      = ohalt_q;
  assign result_o.fault       = ofault_q;

  // checks
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !item_i.ready)
    else $error("item accepted during memory clear");

  a_sp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  a_result_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> $past(busy_q))
    else $error("result appeared without an item in execution");

  a_fault_only_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && ofault_q != sme_pkg::FLT_OK) |-> oexec_q)
    else $error("fault reported on an item that did not execute");

endmodule

`default_nettype wire

>>> verif/stack_machine_executor_top_tb.sv
// stack_machine_executor_top_tb: self-checking bench for the stack machine executor
// directed table then state-aware random instruction sequences, checked by a predictor
// depends on sme_pkg, sme_if and stack_machine_executor_top
`timescale 1ns / 100ps

module stack_machine_executor_top_tb;
  import sme_pkg::*;

  localparam int unsigned STACK_WORDS = DEF_STACK_DEPTH;
  localparam int unsigned DATA_WORDS  = DEF_MEM_WORDS;
  localparam int unsigned PHASE_ITEMS = 320;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_WAIT  = 20;
  localparam int unsigned REPORT_MAX  = 10;
  // highest opcode, past noop, executed as noop
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 4'hF;

  // one result of the block, in typed fields
  typedef struct packed {
    logic              executed;
    logic [WORD_W-1:0] top;
    logic [DEPTH_W-1:0] depth;
    logic              halted;
    fault_e            fault;
  } status_t;

  // one instruction of the stimulus
  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] operand;
  } instr_t;

  // one row of the directed table
  typedef struct {
    instr_t  ins;
    int      reps;
    bit      fixed;
    status_t want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sme_in_if  item_if ();
  sme_out_if result_if ();

  stack_machine_executor_top #(
    .STACK_DEPTH(STACK_WORDS),
    .MEM_WORDS  (DATA_WORDS)
  ) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .result_o(result_if)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // machine state as the predictor sees it
  logic [WORD_W-1:0] arch_stack [STACK_WORDS];
  int unsigned       arch_sp;
  logic [WORD_W-1:0] arch_mem [DATA_WORDS];
  logic [WORD_W-1:0] arch_skip;
  bit                arch_halted;

  status_t     pending_status [$];
  instr_t      plan_q [$];
  int unsigned error_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_req;

  // executes one instruction on the predictor state, returns the status after it
  function automatic status_t exec_instr(logic [KIND_W-1:0] kind, logic [WORD_W-1:0] opnd);
    status_t           st;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    fault_e            flt;
    bit                ran;
    flt = FLT_OK;
    ran = 1'b1;
    if (arch_halted) begin
      ran = 1'b0;
    end else if (arch_skip != '0) begin
      arch_skip = arch_skip - 1;
      ran = 1'b0;
    end else begin
      case (kind)
        KIND_ADD, KIND_NOR: begin
          if (arch_sp < 2) begin
            flt = FLT_UNDER;
          end else begin
            x = arch_stack[arch_sp-1];
            y = arch_stack[arch_sp-2];
            arch_stack[arch_sp-2] = (kind == KIND_ADD) ? x + y : ~(x | y);
            arch_sp--;
          end
        end
        KIND_IFZ: begin
          if (arch_sp < 1) begin
            flt = FLT_UNDER;
          end else begin
            x = arch_stack[arch_sp-1];
            arch_sp--;
            // a negative count skips nothing
            if (x == '0 && !opnd[WORD_W-1]) arch_skip = opnd;
          end
        end
        KIND_HALT: arch_halted = 1'b1;
        KIND_LOAD: begin
          if (arch_sp < 1) begin
            flt = FLT_UNDER;
          end else begin
            x = arch_stack[arch_sp-1];
            if (x >= DATA_WORDS) flt = FLT_ADDR;
            else arch_stack[arch_sp-1] = arch_mem[x];
          end
        end
        KIND_STORE: begin
          if (arch_sp < 2) begin
            flt = FLT_UNDER;
          end else begin
            x = arch_stack[arch_sp-1];
            if (x >= DATA_WORDS) begin
              flt = FLT_ADDR;
            end else begin
              arch_mem[x] = arch_stack[arch_sp-2];
              arch_sp -= 2;
            end
          end
        end
        KIND_POP: begin
          if (arch_sp < 1) flt = FLT_UNDER;
          else arch_sp--;
        end
        KIND_PUSHI: begin
          if (arch_sp >= STACK_WORDS) begin
            flt = FLT_OVER;
          end else begin
            arch_stack[arch_sp] = opnd;
            arch_sp++;
          end
        end
        default: ;
      endcase
    end
    st.executed = ran;
    st.top      = (arch_sp > 0) ? arch_stack[arch_sp-1] : '0;
    st.depth    = DEPTH_W'(arch_sp);
    st.halted   = arch_halted;
    st.fault    = flt;
    return st;
  endfunction

  function automatic status_t status_of(logic ex, logic [WORD_W-1:0] top, int dep, fault_e f);
    status_t st;
    st.executed = ex;
    st.top      = top;
    st.depth    = DEPTH_W'(dep);
    st.halted   = 1'b0;
    st.fault    = f;
    return st;
  endfunction

  function automatic dir_row_t row(logic [KIND_W-1:0] k, logic [WORD_W-1:0] op, int reps);
    dir_row_t r;
    r.ins.kind    = k;
    r.ins.operand = op;
    r.reps        = reps;
    r.fixed       = 1'b0;
    r.want        = '0;
    return r;
  endfunction

  function automatic dir_row_t row_chk(logic [KIND_W-1:0] k, logic [WORD_W-1:0] op,
                                       status_t want);
    dir_row_t r;
    r = row(k, op, 1);
    r.fixed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return WORD_W'($urandom_range(DATA_WORDS - 1));
      default: return $urandom;
    endcase
  endfunction

  // mostly in range, sometimes just past the end or negative
  function automatic logic [WORD_W-1:0] rand_addr();
    case ($urandom_range(19))
      0:       return WORD_W'(DATA_WORDS + $urandom_range(3));
      1:       return $urandom | 32'h8000_0000;
      2:       return $urandom;
      default: return WORD_W'($urandom_range(DATA_WORDS - 1));
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] rand_skip();
    case ($urandom_range(9))
      0:       return $urandom | 32'h8000_0000;
      1:       return WORD_W'($urandom_range(8));
      default: return WORD_W'($urandom_range(3));
    endcase
  endfunction

  function automatic void plan(logic [KIND_W-1:0] k, logic [WORD_W-1:0] op);
    instr_t ins;
    ins.kind    = k;
    ins.operand = op;
    plan_q.push_back(ins);
  endfunction

  // queues one short instruction sequence with random content
  function automatic void plan_sequence();
    int unsigned       r;
    int unsigned       n;
    logic [WORD_W-1:0] a;
    r = $urandom_range(99);
    if (r < 20) begin
      plan(KIND_PUSHI, rand_word());
      plan(KIND_PUSHI, rand_addr());
      plan(KIND_STORE, $urandom);
    end else if (r < 35) begin
      plan(KIND_PUSHI, rand_addr());
      plan(KIND_LOAD, $urandom);
    end else if (r < 50) begin
      plan(KIND_PUSHI, rand_word());
      plan(KIND_PUSHI, rand_word());
      plan($urandom_range(1) ? KIND_ADD : KIND_NOR, $urandom);
    end else if (r < 65) begin
      plan(KIND_PUSHI, $urandom_range(1) ? '0 : rand_word());
      plan(KIND_IFZ, rand_skip());
      if ($urandom_range(9) < 3) plan(KIND_HALT, $urandom);
    end else if (r < 75) begin
      n = $urandom_range(3, 1);
      repeat (n) plan(KIND_POP, $urandom);
    end else if (r < 88) begin
      plan($urandom_range(KIND_SPARE_HI), $urandom);
    end else if (r < 94) begin
      a = WORD_W'($urandom_range(DATA_WORDS - 1));
      plan(KIND_PUSHI, rand_word());
      plan(KIND_PUSHI, a);
      plan(KIND_STORE, $urandom);
      plan(KIND_PUSHI, a);
      plan(KIND_LOAD, $urandom);
    end else if (arch_sp > STACK_WORDS / 2) begin
      // drain past empty
      repeat (arch_sp + 2) plan(KIND_POP, $urandom);
    end else begin
      // fill past full
      repeat (STACK_WORDS - arch_sp + 2) plan(KIND_PUSHI, rand_word());
    end
  endfunction

  // offers one instruction, waits for its accept and books its expected status
  task automatic send_item(instr_t ins, bit fixed, status_t want);
    status_t st;
    while ($urandom_range(99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid   <= 1'b1;
    item_if.kind    <= ins.kind;
    item_if.operand <= ins.operand;
    do @(posedge clk_i); while (!item_if.ready);
    st = exec_instr(ins.kind, ins.operand);
    pending_status.push_back(fixed ? want : st);
  endtask

  function automatic void report(string what, status_t want, status_t got);
    error_cnt++;
    if (error_cnt <= REPORT_MAX)
      $display("mismatch %0s: expected ex=%0b top=%h depth=%0d halt=%0b fault=%0d, got ex=%0b top=%h depth=%0d halt=%0b fault=%0d",
               what, want.executed, want.top, want.depth, want.halted, want.fault,
               got.executed, got.top, got.depth, got.halted, got.fault);
  endfunction

  // result side: check accepted results, drive ready with random stalls and hold-offs
  initial begin : result_side
    status_t     want;
    status_t     got;
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && result_if.valid && result_if.ready) begin
        got.executed = result_if.executed;
        got.top      = result_if.top_value;
        got.depth    = result_if.stack_depth;
        got.halted   = result_if.halted;
        got.fault    = fault_e'(result_if.fault);
        if (pending_status.size() == 0) begin
          report("unexpected result", '0, got);
        end else begin
          want = pending_status.pop_front();
          if (got.executed !== want.executed || got.top !== want.top ||
              got.depth !== want.depth || got.halted !== want.halted ||
              got.fault !== want.fault)
            report("result", want, got);
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // run limit
  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

  // stimulus
  initial begin : item_side
    dir_row_t    dir_rows [$];
    instr_t      ins;
    int unsigned sent;
    int unsigned ph;
    int unsigned n;

    rst_ni            <= 1'b0;
    item_if.valid     <= 1'b0;
    item_if.kind      <= KIND_NOOP;
    item_if.operand   <= '0;
    result_if.ready   <= 1'b0;
    error_cnt      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;

    // predictor reset
    foreach (arch_stack[i]) arch_stack[i] = '0;
    foreach (arch_mem[i]) arch_mem[i] = '0;
    arch_sp     = 0;
    arch_skip   = '0;
    arch_halted = 1'b0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table: underflow on empty stack, extremes, bad addresses,
    // spare opcode, skips over halt, negative skip count, overflow
    dir_rows = '{
      row_chk(KIND_ADD,   '0,           status_of(1, '0, 0, FLT_UNDER)),
      row_chk(KIND_NOR,   '0,           status_of(1, '0, 0, FLT_UNDER)),
      row_chk(KIND_IFZ,   32'd1,        status_of(1, '0, 0, FLT_UNDER)),
      row_chk(KIND_LOAD,  '0,           status_of(1, '0, 0, FLT_UNDER)),
      row_chk(KIND_STORE, '0,           status_of(1, '0, 0, FLT_UNDER)),
      row_chk(KIND_POP,   '0,           status_of(1, '0, 0, FLT_UNDER)),
      row_chk(KIND_PUSHI, 32'h7FFF_FFFF, status_of(1, 32'h7FFF_FFFF, 1, FLT_OK)),
      row_chk(KIND_PUSHI, 32'h8000_0000, status_of(1, 32'h8000_0000, 2, FLT_OK)),
      row_chk(KIND_ADD,   '0,           status_of(1, 32'hFFFF_FFFF, 1, FLT_OK)),
      row_chk(KIND_NOR,   '0,           status_of(1, 32'hFFFF_FFFF, 1, FLT_UNDER)),
      row_chk(KIND_STORE, '0,           status_of(1, 32'hFFFF_FFFF, 1, FLT_UNDER)),
      row_chk(KIND_LOAD,  '0,           status_of(1, 32'hFFFF_FFFF, 1, FLT_ADDR)),
      row(KIND_PUSHI, '0, 1),
      row(KIND_NOR, 32'hFFFF_FFFF, 1),
      row(KIND_PUSHI, WORD_W'(DATA_WORDS), 1),
      row_chk(KIND_LOAD,  '0,           status_of(1, WORD_W'(DATA_WORDS), 2, FLT_ADDR)),
      row(KIND_PUSHI, 32'hDEAD_BEEF, 1),
      row(KIND_PUSHI, WORD_W'(DATA_WORDS - 1), 1),
      row(KIND_STORE, '0, 1),
      row(KIND_POP, '0, 1),
      row(KIND_PUSHI, WORD_W'(DATA_WORDS - 1), 1),
      row(KIND_LOAD, '0, 1),
      row(KIND_SPARE_HI, 32'hFFFF_FFFF, 1),
      row(KIND_NOOP, '0, 1),
      row(KIND_IFZ, 32'd2, 1),
      row(KIND_IFZ, 32'd2, 1),
      row_chk(KIND_HALT,  '0,           status_of(0, '0, 0, FLT_OK)),
      row_chk(KIND_PUSHI, 32'd5,        status_of(0, '0, 0, FLT_OK)),
      row(KIND_PUSHI, '0, 1),
      row_chk(KIND_IFZ,   32'h8000_0000, status_of(1, '0, 0, FLT_OK)),
      row(KIND_PUSHI, 32'h5A5A_5A5A, STACK_WORDS),
      row_chk(KIND_PUSHI, 32'hA5A5_A5A5, status_of(1, 32'h5A5A_5A5A, STACK_WORDS, FLT_OVER)),
      row(KIND_POP, '0, STACK_WORDS)
    };
    foreach (dir_rows[i])
      repeat (dir_rows[i].reps) send_item(dir_rows[i].ins, dir_rows[i].fixed, dir_rows[i].want);

    // random sequences over four idling phases
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  hold_req = 1'b1; end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 13; recv_stall_pct = 13; end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (plan_q.size() == 0) plan_sequence();
        ins = plan_q.pop_front();
        // a halt may only run when it is to be skipped
        if (ins.kind == KIND_HALT && arch_skip == '0) ins.kind = KIND_NOOP;
        send_item(ins, 1'b0, '0);
        sent++;
      end
    end
    plan_q.delete();

    // halt for good, then items that must be ignored
    while (!arch_halted) begin
      ins.kind    = KIND_HALT;
      ins.operand = $urandom;
      send_item(ins, 1'b0, '0);
    end
    for (n = 0; n < 12; n++) begin
      ins.kind    = $urandom_range(KIND_SPARE_HI);
      ins.operand = $urandom;
      send_item(ins, 1'b0, '0);
    end
    item_if.valid <= 1'b0;

    // wait for outstanding results, then a little longer for strays
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> stack_machine_executor_top.f
design/sme_pkg.sv
design/sme_if.sv
design/sme_ram.sv
design/sme_exec.sv
design/stack_machine_executor_top.sv
verif/stack_machine_executor_top_tb.sv
